// ----- design/ufl_pkg.sv -----
// Shared types, constants and codes of the serial loader command engine.
package ufl_pkg;

   localparam int unsigned PayloadBytesDefault = 256;

   localparam logic [7:0] BYTE_SYNC    = 8'h7F;
   localparam logic [7:0] CODE_ERASE   = 8'h43;
   localparam logic [7:0] CODE_WRITE   = 8'h31;
   localparam logic [7:0] CODE_GO      = 8'h21;
   localparam logic [7:0] CODE_RESTORE = 8'h52;
   localparam logic [7:0] BYTE_ACK     = 8'h79;
   localparam logic [7:0] BYTE_NACK    = 8'h1F;
   localparam logic [7:0] BYTE_FILL    = 8'hFF;

   localparam logic [23:0] TIMEOUT_RESET  = 24'd2000000;
   localparam logic [23:0] SLOT0_RESET    = 24'h010000;
   localparam logic [23:0] SLOT1_RESET    = 24'h020000;
   localparam logic [23:0] SLOTX_RESET    = 24'h030000;
   localparam logic [23:0] MAXSIZE_RESET  = 24'd65536;

   typedef enum logic [1:0] {
      OP_BYTE = 2'd0,
      OP_TICK = 2'd1,
      OP_DONE = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      KIND_SEND    = 3'd0,
      KIND_ERASE   = 3'd1,
      KIND_PROGRAM = 3'd2,
      KIND_RESTORE = 3'd3,
      KIND_JUMP    = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      CSR_TIMEOUT  = 3'd0,
      CSR_SLOT0    = 3'd1,
      CSR_SLOT1    = 3'd2,
      CSR_SLOTX    = 3'd3,
      CSR_MAXSIZE  = 3'd4
   } csr_index_type;

   typedef enum logic [3:0] {
      PH_IDLE, PH_COMPL, PH_ERASE_ARG, PH_ADDR, PH_LEN, PH_DATA, PH_WCHK,
      PH_RPARAM, PH_RCHK, PH_WAIT_ERASE, PH_WAIT_PROG, PH_WAIT_RESTORE
   } phase_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] rx_byte;
      logic       op_failed;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  tx_byte;
      logic [31:0] target_address;
      logic [31:0] word_data;
      logic [23:0] restore_size;
      logic        last;
   } rsp_type;

   // Classified word handed from the front to the engine.
   typedef struct packed {
      logic       is_byte;
      logic       is_tick;
      logic       is_done;
      logic [7:0] data;
      logic       failed;
   } cmd_type;

   typedef struct packed {
      logic [23:0] timeout_ticks;
      logic [23:0] slot0_base;
      logic [23:0] slot1_base;
      logic [23:0] slot_other_base;
      logic [23:0] restore_max_size;
   } cfg_type;

endpackage

// ----- design/ufl_front.sv -----
// Input side: accepts words, classifies them and buffers them for the engine.
module ufl_front
   import ufl_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  req_type req_data,
   output logic    full,
   output logic    cmd_valid,
   output cmd_type cmd,
   input  logic    cmd_take
);

   cmd_type    buf_ff [0:1];
   cmd_type    buf_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       accept, store, take;

   // Classify the incoming word; OP_NONE words are not stored.
   always_comb begin
      buf_in.is_byte = (req_data.opcode == OP_BYTE);
      buf_in.is_tick = (req_data.opcode == OP_TICK);
      buf_in.is_done = (req_data.opcode == OP_DONE);
      buf_in.data    = req_data.rx_byte;
      buf_in.failed  = req_data.op_failed;
   end

   assign full      = (cnt_ff == 2'd2);
   assign accept    = push && !full;
   assign store     = accept && (req_data.opcode != OP_NONE);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign take      = cmd_take && cmd_valid;
   assign cmd       = buf_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_ptr_in = store ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = take ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, store} - {1'b0, take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Buffer storage.
   always_ff @(posedge clock) begin
      if (store) begin
         buf_ff[wr_ptr_ff] <= buf_in;
      end
   end

endmodule

// ----- design/ufl_outq.sv -----
// Result queue: takes up to two results a cycle and hands them out in order.
module ufl_outq
   import ufl_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push0,
   input  rsp_type data0,
   input  logic    push1,
   input  rsp_type data1,
   output logic    room2,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   rsp_type    q_ff [0:3];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       take;

   assign empty    = (cnt_ff == 3'd0);
   assign room2    = (cnt_ff <= 3'd2);
   assign take     = pop && !empty;
   assign rsp_data = q_ff[rd_ptr_ff];

   // Pointers advance by the number of words moved.
   always_comb begin
      wr_ptr_in = wr_ptr_ff + {1'b0, push0} + {1'b0, push1};
      rd_ptr_in = rd_ptr_ff + {1'b0, take};
      cnt_in    = cnt_ff + {2'b0, push0} + {2'b0, push1} - {2'b0, take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         cnt_ff    <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push0) begin
         q_ff[wr_ptr_ff] <= data0;
      end
      if (push1) begin
         q_ff[wr_ptr_ff + 2'd1] <= data1;
      end
   end

endmodule

// ----- design/ufl_engine.sv -----
// Command engine: runs the loader protocol on classified words and issues results.
module ufl_engine
   import ufl_pkg::*;
#(
   parameter int unsigned PAYLOAD_BYTES = PayloadBytesDefault
)
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    cmd_valid,
   input  cmd_type cmd,
   output logic    cmd_take,
   input  logic    room2,
   output logic    push0,
   output rsp_type data0,
   output logic    push1,
   output rsp_type data1
);

   localparam int unsigned Words = (PAYLOAD_BYTES + 3) / 4;
   localparam int unsigned WIdx  = (Words > 1) ? $clog2(Words) : 1;
   localparam logic [8:0]  PayMax = 9'(PAYLOAD_BYTES);

   phase_type   phase_ff, phase_in;
   logic [7:0]  code_ff, code_in;
   logic [8:0]  fcnt_ff, fcnt_in;
   logic [39:0] hdr_ff, hdr_in;
   logic [7:0]  xsum_ff, xsum_in;
   logic [8:0]  plen_ff, plen_in;
   logic [6:0]  widx_ff, widx_in;
   logic [23:0] wcnt_ff, wcnt_in;
   logic        aband_ff, aband_in;
   logic        halt_ff, halt_in;
   logic        wpend_ff, wpend_in;
   logic [31:0] mem [0:Words-1];
   logic [31:0] rdata_ff;
   logic        mem_we;
   logic [8:0]  mem_pos;
   logic [31:0] word;
   logic [31:0] size;
   logic [31:0] base;
   logic        got, act, bad;
   logic [8:0]  pos;

   function automatic rsp_type mk(input kind_type k, input logic [7:0] tx,
                                  input logic [31:0] addr, input logic [31:0] dat,
                                  input logic [23:0] sz, input logic lst);
      rsp_type r;
      r.kind           = k;
      r.tx_byte        = tx;
      r.target_address = addr;
      r.word_data      = dat;
      r.restore_size   = sz;
      r.last           = lst;
      return r;
   endfunction

   assign cmd_take = cmd_valid && room2 && !wpend_ff;

   // Program word assembled from the stored lane bytes, padded past the length.
   always_comb begin
      word = '1;
      pos  = '0;
      for (int lane = 0; lane < 4; lane++) begin
         pos = {widx_ff, 2'(lane)};
         if (pos < plen_ff) begin
            word[8*lane +: 8] = rdata_ff[8*lane +: 8];
         end
      end
   end

   // Restore size is sent little-endian; slot selects the base.
   always_comb begin
      size = {hdr_ff[7:0], hdr_ff[15:8], hdr_ff[23:16], hdr_ff[31:24]};
      if (hdr_ff[39:32] == 8'd0) begin
         base = {8'd0, cfg.slot0_base};
      end else if (hdr_ff[39:32] == 8'd1) begin
         base = {8'd0, cfg.slot1_base};
      end else begin
         base = {8'd0, cfg.slot_other_base};
      end
   end

   // Protocol next-state and result logic.
   always_comb begin
      phase_in = phase_ff;
      code_in  = code_ff;
      fcnt_in  = fcnt_ff;
      hdr_in   = hdr_ff;
      xsum_in  = xsum_ff;
      plen_in  = plen_ff;
      widx_in  = widx_ff;
      wcnt_in  = wcnt_ff;
      aband_in = aband_ff;
      halt_in  = halt_ff;
      wpend_in = 1'b0;
      push0    = 1'b0;
      push1    = 1'b0;
      data0    = mk(KIND_SEND, BYTE_ACK, '0, '0, '0, 1'b1);
      data1    = mk(KIND_JUMP, 8'd0, hdr_ff[39:8], '0, '0, 1'b1);
      mem_we   = 1'b0;
      mem_pos  = fcnt_ff;
      got      = cmd.is_byte;
      act      = cmd.is_byte;
      bad      = 1'b0;
      if (wpend_ff) begin
         push0 = 1'b1;
         data0 = mk(KIND_PROGRAM, 8'd0,
                    hdr_ff[39:8] + {23'd0, widx_ff, 2'b00}, word, '0, 1'b1);
      end else if (cmd_take && !halt_ff) begin
         case (phase_ff)
            PH_IDLE: begin
               if (cmd.is_byte) begin
                  if (cmd.data == BYTE_SYNC) begin
                     push0 = 1'b1;
                  end else if (cmd.data inside {CODE_ERASE, CODE_WRITE, CODE_GO,
                                                CODE_RESTORE}) begin
                     code_in  = cmd.data;
                     wcnt_in  = '0;
                     phase_in = PH_COMPL;
                  end
               end
            end
            PH_WAIT_ERASE, PH_WAIT_RESTORE: begin
               if (cmd.is_done) begin
                  push0    = 1'b1;
                  data0    = mk(KIND_SEND, cmd.failed ? BYTE_NACK : BYTE_ACK,
                                '0, '0, '0, 1'b1);
                  phase_in = PH_IDLE;
               end
            end
            PH_WAIT_PROG: begin
               if (cmd.is_done) begin
                  widx_in = widx_ff + 7'd1;
                  if (cmd.failed) begin
                     push0    = 1'b1;
                     data0    = mk(KIND_SEND, BYTE_NACK, '0, '0, '0, 1'b1);
                     phase_in = PH_IDLE;
                     widx_in  = widx_ff;
                  end else if ({2'b0, widx_in} >= ((plen_ff + 9'd3) >> 2)) begin
                     push0    = 1'b1;
                     phase_in = PH_IDLE;
                  end else begin
                     wpend_in = 1'b1;
                  end
               end
            end
            default: begin
               if (cmd.is_tick) begin
                  wcnt_in = wcnt_ff + 24'd1;
                  act = (cfg.timeout_ticks != '0) && (wcnt_in >= cfg.timeout_ticks);
               end
               if (act) begin
                  wcnt_in = '0;
                  case (phase_ff)
                     PH_COMPL: begin
                        if (!got || ((code_ff ^ cmd.data) != 8'hFF)) begin
                           bad = 1'b1;
                        end else begin
                           push0    = 1'b1;
                           fcnt_in  = '0;
                           hdr_in   = '0;
                           xsum_in  = '0;
                           aband_in = 1'b0;
                           if (code_ff == CODE_ERASE) begin
                              phase_in = PH_ERASE_ARG;
                           end else if (code_ff == CODE_RESTORE) begin
                              phase_in = PH_RPARAM;
                           end else begin
                              phase_in = PH_ADDR;
                           end
                        end
                     end
                     PH_ERASE_ARG: begin
                        fcnt_in = fcnt_ff + 9'd1;
                        if (got) begin
                           hdr_in  = {hdr_ff[31:0], cmd.data};
                           xsum_in = xsum_ff ^ cmd.data;
                        end else begin
                           aband_in = 1'b1;
                        end
                        if (fcnt_in >= 9'd2) begin
                           if (aband_in || xsum_in != 8'hFF) begin
                              bad = 1'b1;
                           end else begin
                              push0    = 1'b1;
                              data0    = mk(KIND_ERASE, 8'd0, '0, '0, '0, 1'b1);
                              phase_in = PH_WAIT_ERASE;
                           end
                        end
                     end
                     PH_ADDR: begin
                        if (!got) begin
                           bad = 1'b1;
                        end else begin
                           fcnt_in = fcnt_ff + 9'd1;
                           hdr_in  = {hdr_ff[31:0], cmd.data};
                           xsum_in = xsum_ff ^ cmd.data;
                           if (fcnt_in >= 9'd5) begin
                              if (xsum_in != 8'd0) begin
                                 bad = 1'b1;
                              end else if (code_ff == CODE_GO) begin
                                 push0    = 1'b1;
                                 push1    = 1'b1;
                                 data0    = mk(KIND_SEND, BYTE_ACK, '0, '0, '0, 1'b0);
                                 data1    = mk(KIND_JUMP, 8'd0, hdr_in[39:8], '0, '0,
                                               1'b1);
                                 halt_in  = 1'b1;
                                 phase_in = PH_IDLE;
                              end else begin
                                 push0    = 1'b1;
                                 phase_in = PH_LEN;
                              end
                           end
                        end
                     end
                     PH_LEN: begin
                        if (!got) begin
                           bad = 1'b1;
                        end else begin
                           plen_in  = {1'b0, cmd.data} + 9'd1;
                           xsum_in  = cmd.data;
                           fcnt_in  = '0;
                           aband_in = 1'b0;
                           phase_in = PH_DATA;
                        end
                     end
                     PH_DATA: begin
                        if (!got) begin
                           aband_in = 1'b1;
                           phase_in = PH_WCHK;
                        end else begin
                           mem_we  = (fcnt_ff < PayMax);
                           xsum_in = xsum_ff ^ cmd.data;
                           fcnt_in = fcnt_ff + 9'd1;
                           if (fcnt_in >= plen_ff) begin
                              phase_in = PH_WCHK;
                           end
                        end
                     end
                     PH_WCHK: begin
                        if (!got || aband_ff || cmd.data != xsum_ff || plen_ff > PayMax)
                        begin
                           bad = 1'b1;
                        end else begin
                           widx_in  = '0;
                           wpend_in = 1'b1;
                           phase_in = PH_WAIT_PROG;
                        end
                     end
                     PH_RPARAM: begin
                        if (!got) begin
                           aband_in = 1'b1;
                           phase_in = PH_RCHK;
                        end else begin
                           fcnt_in = fcnt_ff + 9'd1;
                           hdr_in  = {hdr_ff[31:0], cmd.data};
                           xsum_in = xsum_ff ^ cmd.data;
                           if (fcnt_in >= 9'd5) begin
                              phase_in = PH_RCHK;
                           end
                        end
                     end
                     PH_RCHK: begin
                        if (!got || aband_ff || cmd.data != xsum_ff || size == '0
                            || size > {8'd0, cfg.restore_max_size}) begin
                           bad = 1'b1;
                        end else begin
                           push0    = 1'b1;
                           data0    = mk(KIND_RESTORE, 8'd0, base, '0, size[23:0], 1'b1);
                           phase_in = PH_WAIT_RESTORE;
                        end
                     end
                     default: begin
                        phase_in = PH_IDLE;
                     end
                  endcase
                  // Any failed check answers NACK and returns to idle.
                  if (bad) begin
                     push0    = 1'b1;
                     data0    = mk(KIND_SEND, BYTE_NACK, '0, '0, '0, 1'b1);
                     phase_in = PH_IDLE;
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         code_ff  <= '0;
         fcnt_ff  <= '0;
         hdr_ff   <= '0;
         xsum_ff  <= '0;
         plen_ff  <= '0;
         widx_ff  <= '0;
         wcnt_ff  <= '0;
         aband_ff <= 1'b0;
         halt_ff  <= 1'b0;
         wpend_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         code_ff  <= code_in;
         fcnt_ff  <= fcnt_in;
         hdr_ff   <= hdr_in;
         xsum_ff  <= xsum_in;
         plen_ff  <= plen_in;
         widx_ff  <= widx_in;
         wcnt_ff  <= wcnt_in;
         aband_ff <= aband_in;
         halt_ff  <= halt_in;
         wpend_ff <= wpend_in;
      end
   end

   // Payload store: byte-lane writes, registered word read for the next program word.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_pos[WIdx+1:2]][8*mem_pos[1:0] +: 8] <= cmd.data;
      end
      if (wpend_in) begin
         rdata_ff <= mem[widx_in[WIdx-1:0]];
      end
   end

`ifndef SYNTHESIS
   // No new word is consumed while a program word is being built.
   a_no_take_pending: assert property (@(posedge clock) disable iff (reset)
      wpend_ff |-> !cmd_take) else $error("word consumed during program build");

   // Once halted, the engine stays halted.
   a_halt_sticks: assert property (@(posedge clock) disable iff (reset)
      halt_ff |=> halt_ff) else $error("halt state released");

   // A second result is only ever paired with a first one.
   a_push_pair: assert property (@(posedge clock) disable iff (reset)
      push1 |-> push0 && !data0.last && data1.last) else $error("bad result pair");

   // A program word follows only from a completed write checksum or program.
   a_pend_source: assert property (@(posedge clock) disable iff (reset)
      wpend_ff |-> phase_ff == PH_WAIT_PROG) else $error("stray program word");
`endif

endmodule

// ----- design/uart_flash_loader_command_engine_top.sv -----
// Top level of the serial loader command engine: front, engine, result queue, CSRs.
//
//   Channel | Handshake          | Payload
//   --------+--------------------+------------------------------------
//   input   | push / full        | req_data (opcode, rx_byte, op_failed)
//   result  | empty / pop        | rsp_data (kind ... last)
//   config  | csr_valid/csr_ready| csr_index, csr_wdata
//
// A program-word result comes from the registered payload store read; no word
// is consumed while it is pending.
// Input buffering is two words deep and the result queue four deep; the
// engine consumes a word only with room for two results.
// Reset is synchronous and active high; no clearing pass is needed.
module uart_flash_loader_command_engine_top
   import ufl_pkg::*;
#(
   parameter int unsigned PAYLOAD_BYTES = PayloadBytesDefault
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  req_type       req_data,
   output logic          full,
   output logic          empty,
   input  logic          pop,
   output rsp_type       rsp_data,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  csr_index_type csr_index,
   input  logic [23:0]   csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   logic    cmd_valid, cmd_take, room2, push0, push1;
   cmd_type cmd;
   rsp_type data0, data1;

   assign csr_ready = 1'b1;

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_TIMEOUT: cfg_in.timeout_ticks    = csr_wdata;
            CSR_SLOT0:   cfg_in.slot0_base       = csr_wdata;
            CSR_SLOT1:   cfg_in.slot1_base       = csr_wdata;
            CSR_SLOTX:   cfg_in.slot_other_base  = csr_wdata;
            CSR_MAXSIZE: cfg_in.restore_max_size = csr_wdata;
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_ticks    <= TIMEOUT_RESET;
         cfg_ff.slot0_base       <= SLOT0_RESET;
         cfg_ff.slot1_base       <= SLOT1_RESET;
         cfg_ff.slot_other_base  <= SLOTX_RESET;
         cfg_ff.restore_max_size <= MAXSIZE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ufl_front u_front (
      .clock, .reset, .push, .req_data, .full,
      .cmd_valid, .cmd, .cmd_take
   );

   ufl_engine #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_engine (
      .clock, .reset, .cfg(cfg_ff), .cmd_valid, .cmd, .cmd_take,
      .room2, .push0, .data0, .push1, .data1
   );

   ufl_outq u_outq (
      .clock, .reset, .push0, .data0, .push1, .data1,
      .room2, .empty, .pop, .rsp_data
   );

endmodule
